// ===== design/fic_pkg.sv =====
// Shared types, constants and the CRC byte update for the firmware image check.
package fic_pkg;

  // Saturation point of the byte counter is 2**COUNT_BITS.
  localparam int COUNT_BITS = 24;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int MAX_SIZE_W = 24;
  localparam int OUT_CNT_W  = 25;
  localparam int CMP_W      = (CNT_W > MAX_SIZE_W) ? CNT_W : MAX_SIZE_W;

  localparam logic [CNT_W-1:0]      COUNT_LIMIT    = CNT_W'(1) << COUNT_BITS;
  localparam logic [MAX_SIZE_W-1:0] MAX_SIZE_RESET = MAX_SIZE_W'(65536);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] SP_MASK  = 32'hFFFF_0000;
  localparam logic [31:0] SP_BASE  = 32'h2000_0000;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SIZE_ERR = 2'd1;
  localparam logic [1:0] STATUS_HDR_ERR  = 2'd2;

  // One request: an image byte with its markers.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } req_t;

  // One result: the verdict on a whole image.
  typedef struct packed {
    logic [1:0]           status;
    logic [31:0]          checksum;
    logic [OUT_CNT_W-1:0] byte_count;
  } res_t;

  // Reflected CRC-32 update by one byte, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/fic_in_stage.sv =====
// Input register stage: holds one request until the accumulator takes it.
module fic_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  fic_pkg::req_t byte_data,
  output logic          hold_valid,
  output fic_pkg::req_t hold_data,
  input  logic          take
);

  logic load;

  // The register is free when empty or when its request is taken this cycle.
  assign byte_stall = hold_valid && !take;
  assign load       = byte_valid && !byte_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      hold_data <= byte_data;
    end
  end

endmodule

// ===== design/fic_accum.sv =====
// Per-image state: byte count, header word and CRC, plus the final verdict.
module fic_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               max_size_wr,
  input  logic [fic_pkg::MAX_SIZE_W-1:0]     max_size,
  input  logic                               hold_valid,
  input  fic_pkg::req_t                      hold_data,
  input  logic                               slot_free,
  output logic                               take,
  output logic                               res_valid,
  output fic_pkg::res_t                      res_data
);

  logic [fic_pkg::MAX_SIZE_W-1:0] max_size_q;
  logic [31:0]                    crc_accum;
  logic [fic_pkg::CNT_W-1:0]      bytes_seen;
  logic [31:0]                    header_word;

  logic [31:0]                    crc_next;
  logic [fic_pkg::CNT_W-1:0]      count_next;
  logic [31:0]                    header_next;
  logic                           size_bad;
  logic                           hdr_bad;

  // A last request needs room in the output register; others go straight through.
  assign take      = hold_valid && (!hold_data.is_last || slot_free);
  assign res_valid = take && hold_data.is_last;

  // Size limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_size_q <= fic_pkg::MAX_SIZE_RESET;
    end else if (max_size_wr) begin
      max_size_q <= max_size;
    end
  end

  // Fold the byte, if any, into count, header and CRC.
  always_comb begin
    crc_next    = crc_accum;
    count_next  = bytes_seen;
    header_next = header_word;
    if (hold_data.has_byte) begin
      crc_next = fic_pkg::crc_byte(crc_accum, hold_data.data_byte);
      if (bytes_seen < fic_pkg::CNT_W'(4)) begin
        case (bytes_seen[1:0])
          2'd0:    header_next[7:0]   = hold_data.data_byte;
          2'd1:    header_next[15:8]  = hold_data.data_byte;
          2'd2:    header_next[23:16] = hold_data.data_byte;
          default: header_next[31:24] = hold_data.data_byte;
        endcase
      end
      if (bytes_seen < fic_pkg::COUNT_LIMIT) begin
        count_next = bytes_seen + fic_pkg::CNT_W'(1);
      end
    end
  end

  // Verdict on the image as it stands after this request.
  always_comb begin
    size_bad = (count_next == '0) ||
               (fic_pkg::CMP_W'(count_next) > fic_pkg::CMP_W'(max_size_q));
    hdr_bad  = (count_next < fic_pkg::CNT_W'(4)) ||
               ((header_next & fic_pkg::SP_MASK) != fic_pkg::SP_BASE);
    res_data.byte_count = fic_pkg::OUT_CNT_W'(count_next);
    res_data.checksum   = '0;
    if (size_bad) begin
      res_data.status = fic_pkg::STATUS_SIZE_ERR;
    end else if (hdr_bad) begin
      res_data.status = fic_pkg::STATUS_HDR_ERR;
    end else begin
      res_data.status   = fic_pkg::STATUS_OK;
      res_data.checksum = crc_next ^ fic_pkg::CRC_INIT;
    end
  end

  // Image state; a last request starts the next image from scratch.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum   <= fic_pkg::CRC_INIT;
      bytes_seen  <= '0;
      header_word <= '0;
    end else if (take) begin
      if (hold_data.is_last) begin
        crc_accum   <= fic_pkg::CRC_INIT;
        bytes_seen  <= '0;
        header_word <= '0;
      end else begin
        crc_accum   <= crc_next;
        bytes_seen  <= count_next;
        header_word <= header_next;
      end
    end
  end

endmodule

// ===== design/fic_out_stage.sv =====
// Output register: holds a result until the receiver takes it.
module fic_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          res_valid,
  input  fic_pkg::res_t res_data,
  output logic          slot_free,
  output logic          result_valid,
  input  logic          result_stall,
  output fic_pkg::res_t result_data
);

  // Free when empty or when its result leaves this cycle.
  assign slot_free = !result_valid || !result_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      result_data <= res_data;
    end
  end

endmodule

// ===== design/firmware_image_check.sv =====
// Top level of the firmware image check.
//
// An image arrives one byte per request on the byte channel (valid/stall),
// with is_last on its final request; that request may carry a byte or not.
// Each last request yields one result on the result channel: status, the
// CRC-32 of the image (reflected, polynomial 0xEDB88320) when status is ok,
// and the saturating byte count. Other requests yield nothing.
// Throughput is one request per cycle unless a last request waits on the
// output register. A request is registered at accept and folded into the
// image state when taken, which also loads any verdict into result_data.
// The CRC byte update is the longest path: eight unrolled bit steps.
// The user must write max_size with max_size_wr only while no image is in flight; the block does not enforce it.
// Synchronous reset empties both registers, restarts the image state and
// sets max_size to 65536. While the receiver stalls, the held result stays
// put; non-last requests keep flowing, and a last request waits in the
// input register, which then stalls the byte channel.
module firmware_image_check (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           max_size_wr,
  input  logic [fic_pkg::MAX_SIZE_W-1:0] max_size,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  fic_pkg::req_t                  byte_data,
  output logic                           result_valid,
  input  logic                           result_stall,
  output fic_pkg::res_t                  result_data
);

  logic          hold_valid;
  fic_pkg::req_t hold_data;
  logic          take;
  logic          slot_free;
  logic          res_valid;
  fic_pkg::res_t res_data;

  fic_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .hold_valid (hold_valid),
    .hold_data  (hold_data),
    .take       (take)
  );

  fic_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .max_size_wr (max_size_wr),
    .max_size    (max_size),
    .hold_valid  (hold_valid),
    .hold_data   (hold_data),
    .slot_free   (slot_free),
    .take        (take),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  fic_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .slot_free    (slot_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

// ===== design/fic_check.sv =====
// Port-level checks for the firmware image check, bound to the top level.
module fic_check (
  input logic          clk,
  input logic          rst,
  input logic          result_valid,
  input logic          result_stall,
  input fic_pkg::res_t result_data
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // Status is always one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_data.status == fic_pkg::STATUS_OK ||
                      result_data.status == fic_pkg::STATUS_SIZE_ERR ||
                      result_data.status == fic_pkg::STATUS_HDR_ERR))
    else $error("undefined status code");

  // Only an accepted image reports a checksum.
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != fic_pkg::STATUS_OK |->
      result_data.checksum == 32'd0)
    else $error("checksum set on a rejected image");

  // An empty image is always a size error.
  a_empty_size: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.byte_count == '0 |->
      result_data.status == fic_pkg::STATUS_SIZE_ERR)
    else $error("empty image not flagged as size error");

  // An accepted image has at least a full header.
  a_ok_header: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status == fic_pkg::STATUS_OK |->
      result_data.byte_count >= fic_pkg::OUT_CNT_W'(4))
    else $error("short image reported ok");

endmodule

bind firmware_image_check fic_check u_fic_check (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_data  (result_data)
);

// ===== dv/tb.sv =====
// Testbench for the firmware image check: directed and random images checked against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 244;

  // Directed table rows: a request, or a max_size write between images.
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    fic_pkg::req_t                  req;
    logic                           typed;
    fic_pkg::res_t                  res;
    logic [fic_pkg::MAX_SIZE_W-1:0] cfg;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           max_size_wr = 1'b0;
  logic [fic_pkg::MAX_SIZE_W-1:0] max_size = '0;
  logic                           byte_valid = 1'b0;
  logic                           byte_stall;
  fic_pkg::req_t                  byte_data = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  fic_pkg::res_t                  result_data;

  // Predictor state for the image in flight and the size register.
  logic [31:0]                    crc_run;
  logic [fic_pkg::CNT_W-1:0]      seen_cnt;
  logic [31:0]                    sp_word;
  logic [fic_pkg::MAX_SIZE_W-1:0] limit_q;
  fic_pkg::res_t                  pending_verdicts[$];

  int send_idle_pct  = 25;
  int recv_stall_pct = 81;
  int mismatches     = 0;
  int cycle_cnt      = 0;
  int item_count     = 0;
  int cfg_writes     = 0;
  int ok_images      = 0;
  int size_images    = 0;
  int hdr_images     = 0;

  firmware_image_check i_dut (
    .clk          (clk),
    .rst          (rst),
    .max_size_wr  (max_size_wr),
    .max_size     (max_size),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH cycle %0d: %s expected %h got %h", cycle_cnt, what, want, got);
    mismatches++;
  endtask

  // Reflected CRC-32 over one byte, fed least significant bit first.
  function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    int          i;
    c = acc;
    for (i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ fic_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void clear_image();
    crc_run  = fic_pkg::CRC_INIT;
    seen_cnt = '0;
    sp_word  = '0;
  endfunction

  // Fold one accepted request into the image; a last request yields a verdict.
  task automatic fold_request(input fic_pkg::req_t r, input logic typed,
                              input fic_pkg::res_t typed_res);
    fic_pkg::res_t verdict;
    if (r.has_byte) begin
      if (seen_cnt < 4) begin
        sp_word = sp_word | (32'(r.data_byte) << (8 * seen_cnt));
      end
      if (seen_cnt < fic_pkg::COUNT_LIMIT) begin
        seen_cnt = seen_cnt + 1'b1;
      end
      crc_run = crc_step(crc_run, r.data_byte);
    end
    if (r.is_last) begin
      verdict.checksum   = '0;
      verdict.byte_count = fic_pkg::OUT_CNT_W'(seen_cnt);
      // The size check takes precedence over the header check.
      if (seen_cnt == 0 || seen_cnt > fic_pkg::CNT_W'(limit_q)) begin
        verdict.status = fic_pkg::STATUS_SIZE_ERR;
      end else if (seen_cnt < 4 || (sp_word & fic_pkg::SP_MASK) != fic_pkg::SP_BASE) begin
        verdict.status = fic_pkg::STATUS_HDR_ERR;
      end else begin
        verdict.status   = fic_pkg::STATUS_OK;
        verdict.checksum = ~crc_run;
      end
      if (typed) begin
        verdict = typed_res;
      end
      pending_verdicts.push_back(verdict);
      case (verdict.status)
        fic_pkg::STATUS_OK:       ok_images++;
        fic_pkg::STATUS_SIZE_ERR: size_images++;
        default:                  hdr_images++;
      endcase
      clear_image();
    end
  endtask

  // Drive one request, with random idle cycles ahead of it, and wait for accept.
  task automatic send_req(input fic_pkg::req_t r, input logic typed,
                          input fic_pkg::res_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_data  <= r;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall) begin
      @(posedge clk);
    end
    if (r.has_byte || r.is_last) begin
      item_count++;
    end
    fold_request(r, typed, typed_res);
  endtask

  // Stop sending and wait until every verdict has come back and the block settles.
  task automatic drain_pending();
    byte_valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [fic_pkg::MAX_SIZE_W-1:0] v);
    drain_pending();
    max_size    <= v;
    max_size_wr <= 1'b1;
    @(posedge clk);
    max_size_wr <= 1'b0;
    limit_q = v;
    cfg_writes++;
  endtask

  // One random image: mostly well-formed headers, some short, corrupt or oversized.
  task automatic send_image();
    int            len;
    int            sel;
    int            i;
    logic          last_carries;
    logic [15:0]   sp_hi;
    fic_pkg::req_t r;
    sel = $urandom_range(99);
    if (sel < 8) begin
      len = $urandom_range(3);
    end else if (sel < 88) begin
      len = $urandom_range(24, 4);
    end else begin
      len = $urandom_range(80, 25);
    end
    sp_hi = 16'h2000;
    if ($urandom_range(99) < 25) begin
      if ($urandom_range(1) == 1) begin
        sp_hi = 16'($urandom);
      end else begin
        sp_hi = 16'h2000 ^ (16'h1 << $urandom_range(15));
      end
    end
    last_carries = (len > 0) && ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      // Now and then a request with no byte, which the block must ignore.
      if ($urandom_range(99) < 8) begin
        send_req({8'($urandom), 1'b0, 1'b0}, 1'b0, '0);
      end
      r.data_byte = (i == 2) ? sp_hi[7:0] : (i == 3) ? sp_hi[15:8] : 8'($urandom);
      r.has_byte  = 1'b1;
      r.is_last   = last_carries && (i == len - 1);
      send_req(r, 1'b0, '0);
    end
    if (!last_carries) begin
      send_req({8'($urandom), 1'b0, 1'b1}, 1'b0, '0);
    end
  endtask

  function automatic stim_row_t req_row(input logic [7:0] b, input logic h, input logic l);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_REQ;
    row.req  = {b, h, l};
    return row;
  endfunction

  // A row whose verdict is plain from the table itself (error codes, no CRC).
  function automatic stim_row_t exp_row(input logic [7:0] b, input logic h, input logic l,
                                        input logic [1:0] st, input int cnt);
    stim_row_t row;
    row       = req_row(b, h, l);
    row.typed = 1'b1;
    row.res   = {st, 32'd0, fic_pkg::OUT_CNT_W'(cnt)};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [fic_pkg::MAX_SIZE_W-1:0] v);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.cfg  = v;
    return row;
  endfunction

  // Result side: random stall, and every accepted result checked in order.
  always @(posedge clk) begin : check_results
    fic_pkg::res_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with no image pending, status", 32'd0,
                        32'(result_data.status));
      end else begin
        want = pending_verdicts.pop_front();
        if (result_data.status !== want.status) begin
          report_mismatch("status", 32'(want.status), 32'(result_data.status));
        end
        if (result_data.checksum !== want.checksum) begin
          report_mismatch("checksum", want.checksum, result_data.checksum);
        end
        if (result_data.byte_count !== want.byte_count) begin
          report_mismatch("byte_count", 32'(want.byte_count), 32'(result_data.byte_count));
        end
      end
    end
    result_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    stim_row_t                      dir_tab[$];
    logic [fic_pkg::MAX_SIZE_W-1:0] settings[8];
    int                             ph;
    int                             target;

    limit_q = fic_pkg::MAX_SIZE_RESET;
    clear_image();

    // Empty image: a last marker alone, then one after an ignored request.
    dir_tab.push_back(exp_row(8'h00, 1'b0, 1'b1, fic_pkg::STATUS_SIZE_ERR, 0));
    dir_tab.push_back(req_row(8'hAA, 1'b0, 1'b0));
    dir_tab.push_back(exp_row(8'h55, 1'b0, 1'b1, fic_pkg::STATUS_SIZE_ERR, 0));
    // A single byte carried on the last request.
    dir_tab.push_back(exp_row(8'hFF, 1'b1, 1'b1, fic_pkg::STATUS_HDR_ERR, 1));
    // Short image of three bytes.
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'hFF, 1'b1, 1'b0));
    dir_tab.push_back(exp_row(8'h20, 1'b1, 1'b1, fic_pkg::STATUS_HDR_ERR, 3));
    // Smallest good image, stack pointer 0x2000FFFF; the CRC comes from the predictor.
    dir_tab.push_back(req_row(8'hFF, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'hFF, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h20, 1'b1, 1'b1));
    // Stack pointer 0x20010000 is out of range; the last marker comes on its own.
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h01, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h20, 1'b1, 1'b0));
    dir_tab.push_back(exp_row(8'h00, 1'b0, 1'b1, fic_pkg::STATUS_HDR_ERR, 4));
    // With max_size at zero even a good image is too large.
    dir_tab.push_back(cfg_row(24'd0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(exp_row(8'h20, 1'b1, 1'b1, fic_pkg::STATUS_SIZE_ERR, 4));
    // One byte over the limit with a good header: size wins over header.
    dir_tab.push_back(cfg_row(24'd4));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h00, 1'b1, 1'b0));
    dir_tab.push_back(req_row(8'h20, 1'b1, 1'b0));
    dir_tab.push_back(exp_row(8'h5A, 1'b1, 1'b1, fic_pkg::STATUS_SIZE_ERR, 5));

    settings[0] = 24'd65536;
    settings[1] = 24'hFF_FFFF;
    settings[2] = 24'd0;
    settings[3] = 24'd1;
    settings[4] = 24'd4;
    settings[5] = 24'($urandom_range(40, 5));
    settings[6] = 24'($urandom_range(24'hFF_FFFF, 100));
    settings[7] = 24'd65536;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_max_size(dir_tab[i].cfg);
      end else begin
        send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // Random images under each size setting; receiver-heavy stalling, then
    // sender-heavy idling, then none at all.
    for (ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct  = 25;
        recv_stall_pct = 81;
      end else if (ph < 6) begin
        send_idle_pct  = 81;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_max_size(settings[ph]);
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        send_image();
      end
    end

    drain_pending();
    repeat (8) @(posedge clk);

    $display("Checked %0d image verdicts: %0d ok, %0d size errors, %0d header errors.",
             ok_images + size_images + hdr_images, ok_images, size_images, hdr_images);
    $display("Sent %0d byte and end requests over %0d max_size writes, %0d mismatches.",
             item_count, cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
